/* rtl/lgs_pkg.sv */
// Shared types and constants of the life grid generation step unit.
package lgs_pkg;

  // Command codes on in_cmd
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_WRITE = 2'd0;
  localparam cmd_t CMD_READ  = 2'd1;
  localparam cmd_t CMD_STEP  = 2'd2;
  localparam cmd_t CMD_NOP   = 2'd3;

  // Status codes on out_status
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // Configuration register indexes
  typedef logic cfg_idx_t;
  localparam cfg_idx_t CFG_GRID_WIDTH  = 1'b0;
  localparam cfg_idx_t CFG_GRID_HEIGHT = 1'b1;

  // Configuration register values
  typedef logic [6:0] cfg_val_t;
  localparam cfg_val_t GRID_SIZE_RESET = 7'd64;

  // Fixed field widths
  localparam int COORD_W = 6;

  // B3/S23 rule counts and the smallest grid with an inner row
  localparam int BIRTH_COUNT   = 3;
  localparam int SURVIVE_COUNT = 2;
  localparam int MIN_STEP_ROWS = 3;

endpackage

/* rtl/lgs_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module lgs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/lgs_row_eval.sv */
// Next-generation evaluation of one grid row from its rolling three-row window.
module lgs_row_eval #(
  parameter int MAX_COLUMNS = 64
) (
  input  logic [MAX_COLUMNS-1:0] above,
  input  logic [MAX_COLUMNS-1:0] current,
  input  logic [MAX_COLUMNS-1:0] below,
  input  logic [MAX_COLUMNS-1:0] col_mask,
  output logic [MAX_COLUMNS-1:0] next_row
);

  // pad both edges with dead cells; columns beyond the width are masked dead
  logic [MAX_COLUMNS+1:0] pad_a;
  logic [MAX_COLUMNS+1:0] pad_c;
  logic [MAX_COLUMNS+1:0] pad_b;

  assign pad_a = {1'b0, above   & col_mask, 1'b0};
  assign pad_c = {1'b0, current & col_mask, 1'b0};
  assign pad_b = {1'b0, below   & col_mask, 1'b0};

  always_comb begin
    logic [3:0] n;
    logic       live;
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      n = 4'(pad_a[c]) + 4'(pad_a[c+1]) + 4'(pad_a[c+2])
        + 4'(pad_c[c])                  + 4'(pad_c[c+2])
        + 4'(pad_b[c]) + 4'(pad_b[c+1]) + 4'(pad_b[c+2]);
      live = (n == 4'(lgs_pkg::BIRTH_COUNT)) ||
             (current[c] && (n == 4'(lgs_pkg::SURVIVE_COUNT)));
      // keep cells outside the width untouched
      next_row[c] = col_mask[c] ? live : current[c];
    end
  end

endmodule

/* rtl/life_grid_generation_step_unit.sv */
// Top level of the life grid generation step unit (B3/S23 on a stored grid).
//
// The unit holds a cell grid of up to MAX_ROWS x MAX_COLUMNS cells, one grid row per
// entry of a single RAM, cleared at reset through one valid flag per row (no clearing
// pass is needed). A request is taken when start is high and busy is low. Write and
// read requests read the addressed row, and a write then writes it back with the cell
// replaced; their result is registered after the ST_CELL state. A coordinate outside
// the configured grid and the unused command give their result in the cycle after the
// request. A generation step streams the rows through the single RAM read port, one
// row per cycle, keeping the row above and the current row in registers and computing
// the new row as the row below arrives; it holds busy until the last row of the grid
// has arrived and shows its result in the cycle after that. A grid narrower than one
// column or lower than three rows gives its result in the cycle after the request.
// The first and last rows of the grid are left untouched and cells beyond the
// configured size keep their values. Each result shows for exactly one cycle on
// out_valid; the receiver cannot stall it. Write the column count and row count
// registers through the cfg_ port only while the unit is idle.
module life_grid_generation_step_unit #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request channel
  input  logic                     start,
  output logic                     busy,
  input  lgs_pkg::cmd_t            in_cmd,
  input  logic [lgs_pkg::COORD_W-1:0] in_row,
  input  logic [lgs_pkg::COORD_W-1:0] in_column,
  input  logic                     in_cell_in,
  // result channel
  output logic                     out_valid,
  output logic                     out_cell_out,
  output logic                     out_status,
  // configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  lgs_pkg::cfg_idx_t        cfg_index,
  input  lgs_pkg::cfg_val_t        cfg_data
);

  // address and count widths; counts are at least as wide as the config registers
  localparam int RAW  = $clog2(MAX_ROWS);
  localparam int CAW  = $clog2(MAX_COLUMNS);
  localparam int RCW0 = $clog2(MAX_ROWS + 1);
  localparam int CCW0 = $clog2(MAX_COLUMNS + 1);
  localparam int RHW  = (RCW0 > 7) ? RCW0 : 7;
  localparam int CCW  = (CCW0 > 7) ? CCW0 : 7;

  // state codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CELL = 2'd1;
  localparam logic [1:0] ST_STEP = 2'd2;

  logic [1:0]             state_r, state_nxt;
  lgs_pkg::cfg_val_t      col_count_r, row_count_r;
  logic [MAX_ROWS-1:0]    row_valid_r;
  logic                   rd_valid_r;

  // latched cell request
  lgs_pkg::cmd_t          cmd_r, cmd_nxt;
  logic [RAW-1:0]         row_idx_r, row_idx_nxt;
  logic [CAW-1:0]         col_idx_r, col_idx_nxt;
  logic                   val_r, val_nxt;

  // generation sweep
  logic [RHW-1:0]         step_row_r, step_row_nxt;
  logic [MAX_COLUMNS-1:0] above_r, above_nxt;
  logic [MAX_COLUMNS-1:0] cur_r, cur_nxt;

  // result registers
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_cell_r, out_cell_nxt;
  logic                   out_status_r, out_status_nxt;

  // RAM ports
  logic                   ram_we;
  logic [RAW-1:0]         ram_waddr, ram_raddr;
  logic [MAX_COLUMNS-1:0] ram_wdata, ram_rdata;

  logic [RHW-1:0]         used_h;
  logic [CCW-1:0]         used_w;
  logic [RHW-1:0]         req_row;
  logic [CCW-1:0]         req_col;
  logic                   req_inside;
  logic                   step_ok;
  logic [MAX_COLUMNS-1:0] col_mask;
  logic [MAX_COLUMNS-1:0] row_data;
  logic [MAX_COLUMNS-1:0] eval_row;

  // saturate the configured size to the storage size
  assign used_h = (RHW'(row_count_r) > RHW'(MAX_ROWS))    ? RHW'(MAX_ROWS)    :
                                                            RHW'(row_count_r);
  assign used_w = (CCW'(col_count_r) > CCW'(MAX_COLUMNS)) ? CCW'(MAX_COLUMNS) :
                                                            CCW'(col_count_r);

  assign req_row    = RHW'(in_row);
  assign req_col    = CCW'(in_column);
  assign req_inside = (req_row < used_h) && (req_col < used_w);
  assign step_ok    = (used_w != '0) && (used_h >= RHW'(lgs_pkg::MIN_STEP_ROWS));

  // columns inside the configured width
  always_comb begin
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      col_mask[c] = CCW'(c) < used_w;
    end
  end

  // a row never written since reset reads as all dead
  assign row_data = rd_valid_r ? ram_rdata : '0;

  lgs_ram #(
    .WIDTH (MAX_COLUMNS),
    .DEPTH (MAX_ROWS)
  ) u_grid_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lgs_row_eval #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_row_eval (
    .above    (above_r),
    .current  (cur_r),
    .below    (row_data),
    .col_mask (col_mask),
    .next_row (eval_row)
  );

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    row_idx_nxt    = row_idx_r;
    col_idx_nxt    = col_idx_r;
    val_nxt        = val_r;
    step_row_nxt   = step_row_r;
    above_nxt      = above_r;
    cur_nxt        = cur_r;
    out_valid_nxt  = 1'b0;
    out_cell_nxt   = 1'b0;
    out_status_nxt = lgs_pkg::STATUS_OK;
    ram_we         = 1'b0;
    ram_waddr      = row_idx_r;
    ram_wdata      = row_data;
    ram_raddr      = row_idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_cmd) inside
            lgs_pkg::CMD_WRITE, lgs_pkg::CMD_READ: begin
              if (req_inside) begin
                // fetch the addressed row, finish next cycle
                cmd_nxt     = in_cmd;
                row_idx_nxt = req_row[RAW-1:0];
                col_idx_nxt = req_col[CAW-1:0];
                val_nxt     = in_cell_in;
                ram_raddr   = req_row[RAW-1:0];
                state_nxt   = ST_CELL;
              end else begin
                // drop the request and flag the coordinate
                out_valid_nxt  = 1'b1;
                out_status_nxt = lgs_pkg::STATUS_RANGE;
              end
            end
            lgs_pkg::CMD_STEP: begin
              if (step_ok) begin
                // start the sweep with row 0
                ram_raddr    = '0;
                step_row_nxt = RHW'(1);
                state_nxt    = ST_STEP;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_CELL: begin
        if (cmd_r == lgs_pkg::CMD_WRITE) begin
          // write the row back with the one cell replaced
          ram_we               = 1'b1;
          ram_waddr            = row_idx_r;
          ram_wdata            = row_data;
          ram_wdata[col_idx_r] = val_r;
        end else begin
          out_cell_nxt = row_data[col_idx_r];
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      ST_STEP: begin
        // the data now arriving is row step_row_r - 1; fetch the next one
        ram_raddr    = step_row_r[RAW-1:0];
        step_row_nxt = step_row_r + RHW'(1);
        if (step_row_r == RHW'(1)) begin
          above_nxt = row_data;
        end else if (step_row_r == RHW'(2)) begin
          cur_nxt = row_data;
        end else begin
          // new value of the row between the two copies; roll the window
          ram_we    = 1'b1;
          ram_waddr = RAW'(step_row_r - RHW'(2));
          ram_wdata = eval_row;
          above_nxt = cur_r;
          cur_nxt   = row_data;
        end
        if (step_row_r == used_h) begin
          // last row of the grid has arrived: the sweep is complete
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_count_r <= lgs_pkg::GRID_SIZE_RESET;
      row_count_r <= lgs_pkg::GRID_SIZE_RESET;
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        row_valid_r[ram_waddr] <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lgs_pkg::CFG_GRID_WIDTH:  col_count_r <= cfg_data;
          lgs_pkg::CFG_GRID_HEIGHT: row_count_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    rd_valid_r   <= row_valid_r[ram_raddr];
    cmd_r        <= cmd_nxt;
    row_idx_r    <= row_idx_nxt;
    col_idx_r    <= col_idx_nxt;
    val_r        <= val_nxt;
    step_row_r   <= step_row_nxt;
    above_r      <= above_nxt;
    cur_r        <= cur_nxt;
    out_cell_r   <= out_cell_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy         = (state_r != ST_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_cell_out = out_cell_r;
  assign out_status   = out_status_r;

endmodule

/* rtl/lgs_checker.sv */
// Port-level checker of the life grid generation step unit, with its bind.
module lgs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic       out_cell_out,
  input logic       out_status
);

  // a taken request either keeps the unit busy or answers at once
  a_req_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("request neither held nor answered");

  // a result only shows once the unit has gone idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // leaving a multi-cycle operation always delivers its result
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // a live cell is only returned by an in-range read
  a_live_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_cell_out) |-> !out_status)
    else $error("live cell reported with range status");

endmodule

bind life_grid_generation_step_unit lgs_checker u_lgs_checker (.*);
